[rtl/ffha_pkg.sv]
`default_nettype none
package ffha_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int HEAP_BYTES = 1048576;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int ADDR_W = $clog2(HEAP_BYTES + 1);
    localparam int SZ_W   = 27;
    localparam int HDR_W  = 13;
    localparam int SMR_W  = 16;
    localparam int BIG_W  = 21;
    localparam int CMP_W  = ((SZ_W > ADDR_W) ? SZ_W : ADDR_W) + 2;

    localparam logic [1:0] OP_ALLOC  = 2'd0;
    localparam logic [1:0] OP_FREE   = 2'd1;
    localparam logic [1:0] OP_STATUS = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_RANGE     = 3'd1;
    localparam logic [2:0] ST_BIG       = 3'd2;
    localparam logic [2:0] ST_EXHAUSTED = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;

    localparam logic [1:0] CFG_HDR = 2'd0;
    localparam logic [1:0] CFG_SMR = 2'd1;
    localparam logic [1:0] CFG_BIG = 2'd2;
    localparam logic [1:0] CFG_MAX = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] size;
        logic              free;
    } entry_t;

endpackage
`default_nettype wire

[rtl/first_fit_heap_allocator.sv]
// channel | ports                                                  | handshake
// request | opcode, request_size, payload_addr                     | start & !busy
// result  | status, result_addr, free_blocks, free_bytes,          | done, one cycle
//         | total_blocks, total_bytes                              |
// config  | cfg_index, cfg_data                                    | cfg_valid & cfg_ready
// Status requests, range and big-size rejects and frees on an empty table leave busy low;
// done follows in the cycle after accept. Other items walk the table, which has one read
// and one write port, entry by entry through a read and a check state; entry shifts on
// split or merge take a read and a write state each; done follows the last busy cycle.
// Reset inits control state, statistics and config; the table needs no clearing pass.
// busy is high while an item is worked on; results cannot be stalled.
`default_nettype none
module first_fit_heap_allocator (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        start,
    output logic                       busy,
    input  wire [1:0]                  opcode,
    input  wire [ffha_pkg::SZ_W-1:0]   request_size,
    input  wire [ffha_pkg::ADDR_W-1:0] payload_addr,
    output logic                       done,
    output logic [2:0]                 status,
    output logic [ffha_pkg::ADDR_W-1:0] result_addr,
    output logic [ffha_pkg::CNT_W-1:0] free_blocks,
    output logic [ffha_pkg::ADDR_W-1:0] free_bytes,
    output logic [ffha_pkg::CNT_W-1:0] total_blocks,
    output logic [ffha_pkg::ADDR_W-1:0] total_bytes,
    input  wire                        cfg_valid,
    output logic                       cfg_ready,
    input  wire [1:0]                  cfg_index,
    input  wire [ffha_pkg::SZ_W-1:0]   cfg_data
);
    import ffha_pkg::*;

    typedef enum logic [14:0] {
        S_IDLE  = 15'b000000000000001,
        S_ARD   = 15'b000000000000010,
        S_ACHK  = 15'b000000000000100,
        S_APP   = 15'b000000000001000,
        S_SHR   = 15'b000000000010000,
        S_SHW   = 15'b000000000100000,
        S_SPL   = 15'b000000001000000,
        S_AWR   = 15'b000000010000000,
        S_FRD   = 15'b000000100000000,
        S_FCHK  = 15'b000001000000000,
        S_FNRD  = 15'b000010000000000,
        S_FNCHK = 15'b000100000000000,
        S_FMRG  = 15'b001000000000000,
        S_FSR   = 15'b010000000000000,
        S_FSW   = 15'b100000000000000
    } state_t;

    state_t state_reg, state_next;
    logic [CNT_W-1:0]  idx_reg, idx_next, k_reg, k_next, count_reg, count_next;
    logic [1:0]        d_reg, d_next;
    entry_t            cur_reg, cur_next, prev_reg, prev_next, nxt_reg, nxt_next;
    logic              nf_reg, nf_next;
    logic [SZ_W-1:0]   size_reg, size_next;
    logic [ADDR_W-1:0] paddr_reg, paddr_next;
    logic [ADDR_W-1:0] top_reg, top_next;
    logic [CNT_W-1:0]  fb_reg, fb_next;
    logic [ADDR_W-1:0] fbytes_reg, fbytes_next, tbytes_reg, tbytes_next;
    logic [2:0]        status_reg, status_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              done_reg, done_next;
    logic [HDR_W-1:0]  hdr_reg;
    logic [SMR_W-1:0]  smr_reg;
    logic [BIG_W-1:0]  big_reg;
    logic [SZ_W-1:0]   max_reg;

    logic              we;
    logic [IDX_W-1:0]  waddr, raddr;
    entry_t            wdata, rdata;

    ffha_table u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    logic              fit, split_ok, grow_over, app_over, pf;
    logic [ADDR_W-1:0] hdr_a, msize, mstart;
    logic [CNT_W-1:0]  m_idx;

    always_comb
    begin
        hdr_a     = ADDR_W'(hdr_reg);
        fit       = rdata.free && (CMP_W'(rdata.size) >= CMP_W'(size_reg));
        split_ok  = (CMP_W'(rdata.size) >= CMP_W'(size_reg) + CMP_W'(hdr_reg)
                     + CMP_W'(smr_reg)) && (count_reg < CNT_W'(MAX_BLOCKS));
        grow_over = (CMP_W'(top_reg) + CMP_W'(size_reg) - CMP_W'(rdata.size))
                    > CMP_W'(HEAP_BYTES);
        app_over  = (count_reg >= CNT_W'(MAX_BLOCKS)) ||
                    ((CMP_W'(top_reg) + CMP_W'(hdr_reg) + CMP_W'(size_reg))
                     > CMP_W'(HEAP_BYTES));
        pf        = (idx_reg != '0) && prev_reg.free;
        m_idx     = pf ? idx_reg - CNT_W'(1) : idx_reg;
        mstart    = pf ? prev_reg.start : cur_reg.start;
        msize     = (pf ? prev_reg.size + hdr_a : '0) + cur_reg.size
                    + (nf_reg ? hdr_a + nxt_reg.size : '0);
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        k_next      = k_reg;
        count_next  = count_reg;
        d_next      = d_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        nxt_next    = nxt_reg;
        nf_next     = nf_reg;
        size_next   = size_reg;
        paddr_next  = paddr_reg;
        top_next    = top_reg;
        fb_next     = fb_reg;
        fbytes_next = fbytes_reg;
        tbytes_next = tbytes_reg;
        status_next = status_reg;
        addr_next   = addr_reg;
        done_next   = 1'b0;
        we          = 1'b0;
        waddr       = idx_reg[IDX_W-1:0];
        wdata       = cur_reg;
        raddr       = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    size_next  = request_size;
                    paddr_next = payload_addr;
                    idx_next   = '0;
                    addr_next  = '0;
                    case (opcode)
                        OP_ALLOC:
                        begin
                            if (request_size == '0 || request_size > max_reg)
                            begin
                                status_next = ST_RANGE;
                                done_next   = 1'b1;
                            end
                            else if (CMP_W'(request_size) >= CMP_W'(big_reg))
                            begin
                                status_next = ST_BIG;
                                done_next   = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = S_APP;
                            end
                            else
                            begin
                                state_next = S_ARD;
                            end
                        end
                        OP_FREE:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_UNKNOWN;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_FRD;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end
            S_ARD:
            begin
                state_next = S_ACHK;
            end
            S_ACHK:
            begin
                cur_next = rdata;
                if (fit)
                begin
                    if (split_ok)
                    begin
                        k_next = count_reg;
                        state_next = (count_reg > idx_reg + CNT_W'(1)) ? S_SHR : S_SPL;
                    end
                    else
                    begin
                        we          = 1'b1;
                        wdata       = '{start: rdata.start, size: rdata.size, free: 1'b0};
                        fb_next     = fb_reg - CNT_W'(1);
                        fbytes_next = fbytes_reg - rdata.size;
                        status_next = ST_OK;
                        addr_next   = rdata.start;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                end
                else if (idx_reg + CNT_W'(1) == count_reg && rdata.free)
                begin
                    // grow the free tail block in place
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    if (grow_over)
                    begin
                        status_next = ST_EXHAUSTED;
                    end
                    else
                    begin
                        we          = 1'b1;
                        wdata       = '{start: rdata.start, size: size_reg[ADDR_W-1:0],
                                        free: 1'b0};
                        top_next    = top_reg + size_reg[ADDR_W-1:0] - rdata.size;
                        tbytes_next = tbytes_reg + size_reg[ADDR_W-1:0] - rdata.size;
                        fb_next     = fb_reg - CNT_W'(1);
                        fbytes_next = fbytes_reg - rdata.size;
                        status_next = ST_OK;
                        addr_next   = rdata.start;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = (idx_reg + CNT_W'(1) == count_reg) ? S_APP : S_ARD;
                end
            end
            S_APP:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (app_over)
                begin
                    status_next = ST_EXHAUSTED;
                end
                else
                begin
                    we          = 1'b1;
                    waddr       = count_reg[IDX_W-1:0];
                    wdata       = '{start: top_reg + hdr_a, size: size_reg[ADDR_W-1:0],
                                    free: 1'b0};
                    top_next    = top_reg + hdr_a + size_reg[ADDR_W-1:0];
                    count_next  = count_reg + CNT_W'(1);
                    tbytes_next = tbytes_reg + size_reg[ADDR_W-1:0];
                    status_next = ST_OK;
                    addr_next   = top_reg + hdr_a;
                end
            end
            S_SHR:
            begin
                raddr      = k_reg[IDX_W-1:0] - IDX_W'(1);
                state_next = S_SHW;
            end
            S_SHW:
            begin
                we         = 1'b1;
                waddr      = k_reg[IDX_W-1:0];
                wdata      = rdata;
                k_next     = k_reg - CNT_W'(1);
                state_next = (k_reg - CNT_W'(1) > idx_reg + CNT_W'(1)) ? S_SHR : S_SPL;
            end
            S_SPL:
            begin
                we         = 1'b1;
                waddr      = idx_reg[IDX_W-1:0] + IDX_W'(1);
                wdata      = '{start: cur_reg.start + size_reg[ADDR_W-1:0] + hdr_a,
                               size: cur_reg.size - size_reg[ADDR_W-1:0] - hdr_a,
                               free: 1'b1};
                count_next = count_reg + CNT_W'(1);
                state_next = S_AWR;
            end
            S_AWR:
            begin
                we          = 1'b1;
                wdata       = '{start: cur_reg.start, size: size_reg[ADDR_W-1:0], free: 1'b0};
                tbytes_next = tbytes_reg - hdr_a;
                fbytes_next = fbytes_reg - size_reg[ADDR_W-1:0] - hdr_a;
                status_next = ST_OK;
                addr_next   = cur_reg.start;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_FRD:
            begin
                state_next = S_FCHK;
            end
            S_FCHK:
            begin
                if (rdata.start == paddr_reg)
                begin
                    cur_next = rdata;
                    nf_next  = 1'b0;
                    state_next = (idx_reg + CNT_W'(1) < count_reg) ? S_FNRD : S_FMRG;
                end
                else
                begin
                    prev_next = rdata;
                    idx_next  = idx_reg + CNT_W'(1);
                    if (idx_reg + CNT_W'(1) == count_reg)
                    begin
                        status_next = ST_UNKNOWN;
                        done_next   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_FRD;
                    end
                end
            end
            S_FNRD:
            begin
                raddr      = idx_reg[IDX_W-1:0] + IDX_W'(1);
                state_next = S_FNCHK;
            end
            S_FNCHK:
            begin
                nxt_next   = rdata;
                nf_next    = rdata.free;
                state_next = S_FMRG;
            end
            S_FMRG:
            begin
                // merged block lands at the lower neighbor when that one is free
                we          = 1'b1;
                waddr       = m_idx[IDX_W-1:0];
                wdata       = '{start: mstart, size: msize, free: 1'b1};
                d_next      = {1'b0, pf} + {1'b0, nf_reg};
                fb_next     = fb_reg + CNT_W'(!cur_reg.free) - CNT_W'(pf) - CNT_W'(nf_reg);
                tbytes_next = tbytes_reg + (pf ? hdr_a : '0) + (nf_reg ? hdr_a : '0);
                fbytes_next = fbytes_reg + (cur_reg.free ? '0 : cur_reg.size)
                              + (pf ? hdr_a : '0) + (nf_reg ? hdr_a : '0);
                k_next      = m_idx + CNT_W'(1);
                if (!pf && !nf_reg)
                begin
                    status_next = ST_OK;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (m_idx + CNT_W'(1) + CNT_W'(pf) + CNT_W'(nf_reg) < count_reg)
                begin
                    state_next = S_FSR;
                end
                else
                begin
                    count_next  = count_reg - CNT_W'(pf) - CNT_W'(nf_reg);
                    status_next = ST_OK;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_FSR:
            begin
                raddr      = k_reg[IDX_W-1:0] + IDX_W'(d_reg);
                state_next = S_FSW;
            end
            S_FSW:
            begin
                we     = 1'b1;
                waddr  = k_reg[IDX_W-1:0];
                wdata  = rdata;
                k_next = k_reg + CNT_W'(1);
                if (k_reg + CNT_W'(1) + CNT_W'(d_reg) < count_reg)
                begin
                    state_next = S_FSR;
                end
                else
                begin
                    count_next  = count_reg - CNT_W'(d_reg);
                    status_next = ST_OK;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            top_reg    <= '0;
            fb_reg     <= '0;
            fbytes_reg <= '0;
            tbytes_reg <= '0;
            done_reg   <= 1'b0;
            hdr_reg    <= HDR_W'(40);
            smr_reg    <= SMR_W'(128);
            big_reg    <= BIG_W'(131072);
            max_reg    <= SZ_W'(100000000);
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            top_reg    <= top_next;
            fb_reg     <= fb_next;
            fbytes_reg <= fbytes_next;
            tbytes_reg <= tbytes_next;
            done_reg   <= done_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_HDR: hdr_reg <= cfg_data[HDR_W-1:0];
                    CFG_SMR: smr_reg <= cfg_data[SMR_W-1:0];
                    CFG_BIG: big_reg <= cfg_data[BIG_W-1:0];
                    CFG_MAX: max_reg <= cfg_data;
                    default: max_reg <= max_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        k_reg      <= k_next;
        d_reg      <= d_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        nxt_reg    <= nxt_next;
        nf_reg     <= nf_next;
        size_reg   <= size_next;
        paddr_reg  <= paddr_next;
        status_reg <= status_next;
        addr_reg   <= addr_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign result_addr  = addr_reg;
    assign free_blocks  = fb_reg;
    assign free_bytes   = fbytes_reg;
    assign total_blocks = count_reg;
    assign total_bytes  = tbytes_reg;
    assign cfg_ready    = 1'b1;
endmodule
`default_nettype wire

[rtl/ffha_table.sv]
`default_nettype none
module ffha_table (
    input  wire                     clk,
    input  wire                     we,
    input  wire [ffha_pkg::IDX_W-1:0] waddr,
    input  ffha_pkg::entry_t        wdata,
    input  wire [ffha_pkg::IDX_W-1:0] raddr,
    output ffha_pkg::entry_t        rdata
);
    import ffha_pkg::*;

    entry_t mem [MAX_BLOCKS];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

[bench/first_fit_heap_allocator_test.sv]
module first_fit_heap_allocator_test;
    import ffha_pkg::*;

    localparam int LIMIT = 4000000;

    typedef struct packed {
        logic [2:0]        status;
        logic [ADDR_W-1:0] result_addr;
        logic [CNT_W-1:0]  free_blocks;
        logic [ADDR_W-1:0] free_bytes;
        logic [CNT_W-1:0]  total_blocks;
        logic [ADDR_W-1:0] total_bytes;
    } heap_report_t;

    typedef struct {
        logic [1:0]      op;
        logic [SZ_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        bit              typed;
        heap_report_t    report;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] opcode;
    logic [SZ_W-1:0] request_size;
    logic [ADDR_W-1:0] payload_addr;
    logic done;
    logic [2:0] status;
    logic [ADDR_W-1:0] result_addr;
    logic [CNT_W-1:0] free_blocks;
    logic [ADDR_W-1:0] free_bytes;
    logic [CNT_W-1:0] total_blocks;
    logic [ADDR_W-1:0] total_bytes;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [SZ_W-1:0] cfg_data;

    first_fit_heap_allocator u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .opcode(opcode), .request_size(request_size), .payload_addr(payload_addr),
        .done(done), .status(status), .result_addr(result_addr),
        .free_blocks(free_blocks), .free_bytes(free_bytes),
        .total_blocks(total_blocks), .total_bytes(total_bytes),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow heap
    longint unsigned hdr_bytes, split_min, big_limit, req_limit;
    longint unsigned blk_start [MAX_BLOCKS];
    longint unsigned blk_size [MAX_BLOCKS];
    bit              blk_free [MAX_BLOCKS];
    int              blk_count;
    longint unsigned heap_top;

    heap_report_t pending_reports[$];
    int mismatches;
    int cycles;
    int burst_left;

    function automatic void merge_with_next(int i);
        blk_size[i] = blk_size[i] + hdr_bytes + blk_size[i+1];
        for (int k = i + 1; k + 1 < blk_count; k++)
        begin
            blk_start[k] = blk_start[k+1];
            blk_size[k]  = blk_size[k+1];
            blk_free[k]  = blk_free[k+1];
        end
        blk_count--;
    endfunction

    function automatic heap_report_t heap_step(logic [1:0] op, logic [SZ_W-1:0] req,
                                               logic [ADDR_W-1:0] paddr);
        heap_report_t r;
        longint unsigned sz, grant, grow, fbytes, tbytes;
        logic [2:0] st;
        bit found, nxt, prv;
        int fb;
        sz = req;
        st = ST_OK;
        grant = 0;
        found = 0;
        if (op == OP_ALLOC)
        begin
            if (sz == 0 || sz > req_limit)
                st = ST_RANGE;
            else if (sz >= big_limit)
                st = ST_BIG;
            else
            begin
                for (int i = 0; i < blk_count && !found; i++)
                begin
                    if (blk_free[i] && blk_size[i] >= sz)
                    begin
                        if (blk_size[i] >= sz + hdr_bytes + split_min && blk_count < MAX_BLOCKS)
                        begin
                            for (int k = blk_count; k > i + 1; k--)
                            begin
                                blk_start[k] = blk_start[k-1];
                                blk_size[k]  = blk_size[k-1];
                                blk_free[k]  = blk_free[k-1];
                            end
                            blk_start[i+1] = blk_start[i] + sz + hdr_bytes;
                            blk_size[i+1]  = blk_size[i] - sz - hdr_bytes;
                            blk_free[i+1]  = 1;
                            blk_count++;
                            blk_size[i] = sz;
                        end
                        blk_free[i] = 0;
                        grant = blk_start[i];
                        found = 1;
                    end
                    else if (i + 1 == blk_count && blk_free[i])
                    begin
                        // last block free but short: grow it at the heap top
                        found = 1;
                        grow = sz - blk_size[i];
                        if (heap_top + grow > HEAP_BYTES)
                            st = ST_EXHAUSTED;
                        else
                        begin
                            heap_top += grow;
                            blk_size[i] = sz;
                            blk_free[i] = 0;
                            grant = blk_start[i];
                        end
                    end
                end
                if (!found)
                begin
                    if (blk_count >= MAX_BLOCKS || heap_top + hdr_bytes + sz > HEAP_BYTES)
                        st = ST_EXHAUSTED;
                    else
                    begin
                        blk_start[blk_count] = heap_top + hdr_bytes;
                        blk_size[blk_count]  = sz;
                        blk_free[blk_count]  = 0;
                        heap_top += hdr_bytes + sz;
                        grant = blk_start[blk_count];
                        blk_count++;
                    end
                end
            end
        end
        else if (op == OP_FREE)
        begin
            st = ST_UNKNOWN;
            for (int i = 0; i < blk_count && !found; i++)
            begin
                if (blk_start[i] == longint'(paddr))
                begin
                    found = 1;
                    st = ST_OK;
                    nxt = (i + 1 < blk_count) && blk_free[i+1];
                    prv = (i > 0) && blk_free[i-1];
                    blk_free[i] = 1;
                    if (nxt)
                        merge_with_next(i);
                    if (prv)
                        merge_with_next(i - 1);
                end
            end
        end
        fb = 0;
        fbytes = 0;
        tbytes = 0;
        for (int i = 0; i < blk_count; i++)
        begin
            tbytes += blk_size[i];
            if (blk_free[i])
            begin
                fb++;
                fbytes += blk_size[i];
            end
        end
        r.status       = st;
        r.result_addr  = grant[ADDR_W-1:0];
        r.free_blocks  = fb[CNT_W-1:0];
        r.free_bytes   = fbytes[ADDR_W-1:0];
        r.total_blocks = blk_count[CNT_W-1:0];
        r.total_bytes  = tbytes[ADDR_W-1:0];
        return r;
    endfunction

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("first_fit_heap_allocator_test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        heap_report_t got, want;
        if (rst_n && done)
        begin
            got = {status, result_addr, free_blocks, free_bytes, total_blocks, total_bytes};
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: %p", got);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // one request; the sender runs in bursts with random gaps between them
    task automatic send_item(logic [1:0] op, logic [SZ_W-1:0] sz, logic [ADDR_W-1:0] pa,
                             bit typed, heap_report_t typed_report);
        heap_report_t pred;
        start <= 1'b1;
        opcode <= op;
        request_size <= sz;
        payload_addr <= pa;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pred = heap_step(op, sz, pa);
        pending_reports.push_back(typed ? typed_report : pred);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 20);
            if ($urandom_range(0, 3) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 8))
                    @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        if (start)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        while (pending_reports.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, longint unsigned val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[SZ_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_HDR: hdr_bytes = val & 64'h1FFF;
            CFG_SMR: split_min = val & 64'hFFFF;
            CFG_BIG: big_limit = val & 64'h1FFFFF;
            default: req_limit = val & 64'h7FFFFFF;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_items(int count, int drain_at);
        heap_report_t none;
        logic [1:0] op;
        logic [SZ_W-1:0] sz;
        logic [ADDR_W-1:0] pa;
        int pick;
        none = '0;
        for (int n = 0; n < count; n++)
        begin
            if (n == drain_at)
                drain();
            pick = $urandom_range(0, 99);
            sz = SZ_W'($urandom_range(1, 2000));
            pa = ADDR_W'($urandom());
            op = OP_ALLOC;
            if (pick < 30)
                sz = SZ_W'($urandom_range(1, 2000));
            else if (pick < 40)
                sz = SZ_W'($urandom_range(2000, 300000));
            else if (pick < 45)
                sz = SZ_W'($urandom());
            else if (pick < 48)
                sz = (pick == 45) ? '0 : req_limit[SZ_W-1:0];
            else if (pick < 88)
            begin
                op = OP_FREE;
                if (blk_count > 0)
                    pa = blk_start[$urandom_range(0, blk_count - 1)][ADDR_W-1:0];
            end
            else if (pick < 94)
                op = OP_FREE;
            else
                op = (pick < 97) ? OP_STATUS : 2'd3;
            send_item(op, sz, pa, 0, none);
        end
    endtask

    initial
    begin
        stim_row_t rows[$];
        heap_report_t none;
        none = '0;
        rst_n = 1'b0;
        start = 1'b0;
        opcode = OP_STATUS;
        request_size = '0;
        payload_addr = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_HDR;
        cfg_data = '0;
        cycles = 0;
        mismatches = 0;
        burst_left = 0;
        hdr_bytes = 40;
        split_min = 128;
        big_limit = 131072;
        req_limit = 100000000;
        blk_count = 0;
        heap_top = 0;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = '{
            '{OP_STATUS, 0, 0, 1, '{ST_OK, 0, 0, 0, 0, 0}},
            '{OP_ALLOC, 0, 0, 1, '{ST_RANGE, 0, 0, 0, 0, 0}},
            '{OP_ALLOC, 100000001, 0, 1, '{ST_RANGE, 0, 0, 0, 0, 0}},
            '{OP_ALLOC, 27'h7FFFFFF, 0, 1, '{ST_RANGE, 0, 0, 0, 0, 0}},
            '{OP_ALLOC, 131072, 0, 1, '{ST_BIG, 0, 0, 0, 0, 0}},
            '{OP_FREE, 0, 0, 1, '{ST_UNKNOWN, 0, 0, 0, 0, 0}},
            '{OP_FREE, 0, 21'h1FFFFF, 1, '{ST_UNKNOWN, 0, 0, 0, 0, 0}},
            '{OP_ALLOC, 100, 0, 1, '{ST_OK, 40, 0, 0, 1, 100}},
            '{OP_ALLOC, 1000, 0, 0, none},
            '{OP_ALLOC, 500, 0, 0, none},
            '{OP_FREE, 0, 40, 0, none},
            '{OP_FREE, 0, 40, 0, none},
            '{OP_ALLOC, 50, 0, 0, none},
            '{OP_FREE, 0, 180, 0, none},
            '{OP_ALLOC, 300, 0, 0, none},
            '{OP_FREE, 0, 1220, 0, none},
            '{OP_ALLOC, 3000, 0, 0, none},
            '{OP_FREE, 0, 180, 0, none},
            '{OP_FREE, 0, 40, 0, none},
            '{OP_ALLOC, 131071, 0, 0, none},
            '{OP_ALLOC, 131071, 0, 0, none},
            '{OP_ALLOC, 1, 0, 0, none},
            '{2'd3, 0, 0, 0, none},
            '{OP_ALLOC, 100000000, 0, 0, none}
        };
        foreach (rows[i])
            send_item(rows[i].op, rows[i].size, rows[i].addr, rows[i].typed, rows[i].report);

        random_items(380, 150);

        write_reg(CFG_HDR, 0);
        write_reg(CFG_SMR, 0);
        random_items(300, -1);

        // big headers and a large split minimum; big requests open up to fill the heap
        write_reg(CFG_HDR, 4096);
        write_reg(CFG_SMR, 65535);
        write_reg(CFG_BIG, 1048576);
        random_items(300, -1);

        write_reg(CFG_BIG, 1);
        write_reg(CFG_MAX, 1);
        random_items(150, -1);

        write_reg(CFG_MAX, 100000000);
        write_reg(CFG_BIG, 131072);
        write_reg(CFG_HDR, 40);
        write_reg(CFG_SMR, 128);
        random_items(250, -1);

        repeat (2)
        begin
            write_reg(CFG_HDR, $urandom_range(0, 8191));
            write_reg(CFG_SMR, $urandom_range(0, 65535));
            write_reg(CFG_BIG, $urandom_range(1, 2097151));
            write_reg(CFG_MAX, $urandom_range(1, 134217727));
            random_items(250, -1);
        end

        drain();
        repeat (300)
            @(posedge clk);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("first_fit_heap_allocator_test passed");
        else
            $display("first_fit_heap_allocator_test failed");
        $finish;
    end

endmodule
